[src/qfn_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qfn_pkg
// Shared constants and types for the quad face unit normal pipeline.
// ----------------------------------------------------------------------------
package qfn_pkg;

   // default widths of the top level
   localparam int COORD_BITS_DEF       = 24;
   localparam int NORMAL_FRAC_BITS_DEF = 14;

   // fixed output width of each normal component
   localparam int NORMAL_BITS = 16;

   // normalisation window: largest magnitude lands in [2^29, 2^30)
   localparam int WIN_BITS   = 30;
   localparam int SQ_BITS    = 2 * WIN_BITS;
   localparam int LEN2_BITS  = SQ_BITS + 2;
   localparam int ROOT_BITS  = LEN2_BITS / 2;
   localparam int TRIAL_BITS = LEN2_BITS + 2;

   // per-item side information carried down the pipe
   typedef struct packed {
      logic [2:0] neg;
      logic       zero;
   } face_flags_type;

endpackage
`default_nettype wire

[src/qfn_isqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qfn_isqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module qfn_isqrt import qfn_pkg::*; (
   input  logic                 clock,
   input  logic                 adv,
   input  logic [LEN2_BITS-1:0] len2,
   output logic [ROOT_BITS-1:0] root
);

   logic [TRIAL_BITS-1:0] rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0]  root_ff [ROOT_BITS];

   genvar i;
   generate
      for (i = 0; i < ROOT_BITS; i++) begin : g_step
         localparam int B = ROOT_BITS - 1 - i;
         logic [TRIAL_BITS-1:0] rem_q;
         logic [ROOT_BITS-1:0]  root_q;
         logic [TRIAL_BITS-1:0] trial;
         logic [TRIAL_BITS-1:0] rem_in;
         logic [ROOT_BITS-1:0]  root_in;

         if (i == 0) begin : g_first
            assign rem_q  = TRIAL_BITS'(len2);
            assign root_q = '0;
         end else begin : g_next
            assign rem_q  = rem_ff[i-1];
            assign root_q = root_ff[i-1];
         end

         // try setting bit B of the root
         always_comb begin
            trial = (TRIAL_BITS'(root_q) << (B + 1)) | (TRIAL_BITS'(1) << (2 * B));
            if (rem_q >= trial) begin
               rem_in  = rem_q - trial;
               root_in = root_q | (ROOT_BITS'(1) << B);
            end else begin
               rem_in  = rem_q;
               root_in = root_q;
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[i]  <= rem_in;
               root_ff[i] <= root_in;
            end
         end
      end
   endgenerate

   assign root = root_ff[ROOT_BITS-1];

endmodule
`default_nettype wire

[src/qfn_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qfn_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module qfn_div import qfn_pkg::*; #(
   parameter int NUM_BITS = WIN_BITS + NORMAL_FRAC_BITS_DEF + 1,
   parameter int DEN_BITS = ROOT_BITS,
   parameter int Q_BITS   = NORMAL_FRAC_BITS_DEF + 1
) (
   input  logic                clock,
   input  logic                adv,
   input  logic [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0] den,
   output logic [Q_BITS-1:0]   quo
);

   localparam int SW = DEN_BITS + Q_BITS;

   logic [SW-1:0]       rem_ff [Q_BITS];
   logic [DEN_BITS-1:0] den_ff [Q_BITS];
   logic [Q_BITS-1:0]   q_ff   [Q_BITS];

   genvar k;
   generate
      for (k = 0; k < Q_BITS; k++) begin : g_step
         localparam int B = Q_BITS - 1 - k;
         logic [SW-1:0]       rem_q;
         logic [DEN_BITS-1:0] den_q;
         logic [Q_BITS-1:0]   q_q;
         logic [SW-1:0]       trial;
         logic [SW-1:0]       rem_in;
         logic [Q_BITS-1:0]   q_in;

         if (k == 0) begin : g_first
            assign rem_q = SW'(num);
            assign den_q = den;
            assign q_q   = '0;
         end else begin : g_next
            assign rem_q = rem_ff[k-1];
            assign den_q = den_ff[k-1];
            assign q_q   = q_ff[k-1];
         end

         // compare against the shifted divisor
         always_comb begin
            trial = SW'(den_q) << B;
            if (rem_q >= trial) begin
               rem_in = rem_q - trial;
               q_in   = q_q | (Q_BITS'(1) << B);
            end else begin
               rem_in = rem_q;
               q_in   = q_q;
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k] <= rem_in;
               den_ff[k] <= den_q;
               q_ff[k]   <= q_in;
            end
         end
      end
   endgenerate

   assign quo = q_ff[Q_BITS-1];

endmodule
`default_nettype wire

[src/quad_face_unit_normal.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// quad_face_unit_normal
// Unit normal of a quadrilateral face: corner choice, cross product,
// normalisation to a signed fixed-point unit vector.
// ----------------------------------------------------------------------------
//  channel | ports            | handshake     | item
//  input   | req_c1_x..c4_z   | valid / ready | four corners, signed Q16.8
//  result  | rsp_normal_*     | valid / ready | normal Q1.14, zero_length flag
//
// One item enters per cycle while the result side is not stalled; the pipe
// holds the square root (one bit per stage) and the three divider lanes
// (one quotient bit per stage). A stalled result holds the whole pipe
// in place; nothing is lost or repeated. Synchronous reset clears the valid
// bits only.
// ----------------------------------------------------------------------------
module quad_face_unit_normal import qfn_pkg::*; #(
   parameter int COORD_BITS       = COORD_BITS_DEF,
   parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_BITS-1:0]  req_c1_x,
   input  logic signed [COORD_BITS-1:0]  req_c1_y,
   input  logic signed [COORD_BITS-1:0]  req_c1_z,
   input  logic signed [COORD_BITS-1:0]  req_c2_x,
   input  logic signed [COORD_BITS-1:0]  req_c2_y,
   input  logic signed [COORD_BITS-1:0]  req_c2_z,
   input  logic signed [COORD_BITS-1:0]  req_c3_x,
   input  logic signed [COORD_BITS-1:0]  req_c3_y,
   input  logic signed [COORD_BITS-1:0]  req_c3_z,
   input  logic signed [COORD_BITS-1:0]  req_c4_x,
   input  logic signed [COORD_BITS-1:0]  req_c4_y,
   input  logic signed [COORD_BITS-1:0]  req_c4_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [NORMAL_BITS-1:0] rsp_normal_x,
   output logic signed [NORMAL_BITS-1:0] rsp_normal_y,
   output logic signed [NORMAL_BITS-1:0] rsp_normal_z,
   output logic                          rsp_zero_length
);

   localparam int UW    = COORD_BITS + 1;
   localparam int PW    = 2 * UW;
   localparam int CW    = PW + 1;
   localparam int LENW  = $clog2(CW + 1);
   localparam int QW    = NORMAL_FRAC_BITS + 1;
   localparam int NUMW  = WIN_BITS + NORMAL_FRAC_BITS + 1;
   localparam int EW    = (NORMAL_FRAC_BITS + 2 > NORMAL_BITS) ?
                          NORMAL_FRAC_BITS + 2 : NORMAL_BITS;
   localparam int VLAT  = 8 + ROOT_BITS + QW;

   // pipe advance
   logic adv;
   logic rsp_valid_ff;
   logic [VLAT-1:0] vld_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[VLAT-2:0], req_valid};
         rsp_valid_ff <= vld_ff[VLAT-1];
      end
   end

   // stage 1: corner choice and edge vectors
   logic signed [COORD_BITS-1:0] p_c [3];
   logic signed [COORD_BITS-1:0] q_c [3];
   logic signed [COORD_BITS-1:0] r_c [3];
   logic eq12, eq23;
   logic signed [UW-1:0] u_ff [3];
   logic signed [UW-1:0] v_ff [3];

   always_comb begin
      eq12 = (req_c1_x == req_c2_x) && (req_c1_y == req_c2_y) && (req_c1_z == req_c2_z);
      eq23 = (req_c2_x == req_c3_x) && (req_c2_y == req_c3_y) && (req_c2_z == req_c3_z);
      priority if (eq23) begin
         p_c = '{req_c1_x, req_c1_y, req_c1_z};
         q_c = '{req_c3_x, req_c3_y, req_c3_z};
         r_c = '{req_c4_x, req_c4_y, req_c4_z};
      end else if (eq12) begin
         p_c = '{req_c2_x, req_c2_y, req_c2_z};
         q_c = '{req_c3_x, req_c3_y, req_c3_z};
         r_c = '{req_c4_x, req_c4_y, req_c4_z};
      end else begin
         p_c = '{req_c1_x, req_c1_y, req_c1_z};
         q_c = '{req_c2_x, req_c2_y, req_c2_z};
         r_c = '{req_c3_x, req_c3_y, req_c3_z};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            u_ff[j] <= UW'(q_c[j]) - UW'(p_c[j]);
            v_ff[j] <= UW'(r_c[j]) - UW'(p_c[j]);
         end
      end
   end

   // stage 2: six partial products
   logic signed [PW-1:0] p_ff [6];

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff[0] <= u_ff[1] * v_ff[2];
         p_ff[1] <= u_ff[2] * v_ff[1];
         p_ff[2] <= u_ff[2] * v_ff[0];
         p_ff[3] <= u_ff[0] * v_ff[2];
         p_ff[4] <= u_ff[0] * v_ff[1];
         p_ff[5] <= u_ff[1] * v_ff[0];
      end
   end

   // stage 3: cross product
   logic signed [CW-1:0] cr_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            cr_ff[j] <= CW'(p_ff[2*j]) - CW'(p_ff[2*j+1]);
         end
      end
   end

   // stage 4: magnitudes and signs
   logic [CW-1:0] mag_ff [3];
   logic [2:0]    neg4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            mag_ff[j]  <= cr_ff[j][CW-1] ? CW'(-cr_ff[j]) : CW'(cr_ff[j]);
            neg4_ff[j] <= cr_ff[j][CW-1];
         end
      end
   end

   // stage 5: bit length of the largest magnitude
   logic [CW-1:0]   mag_or;
   logic [LENW-1:0] len_in;
   logic [LENW-1:0] len_ff;
   logic [CW-1:0]   mag5_ff [3];
   logic [2:0]      neg5_ff;

   always_comb begin
      mag_or = mag_ff[0] | mag_ff[1] | mag_ff[2];
      len_in = '0;
      for (int i = 0; i < CW; i++) begin
         if (mag_or[i]) begin
            len_in = LENW'(i + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         len_ff  <= len_in;
         mag5_ff <= mag_ff;
         neg5_ff <= neg4_ff;
      end
   end

   // stage 6: common shift into the window
   logic [WIN_BITS-1:0] m6_ff [3];
   face_flags_type      flg6_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            m6_ff[j] <= WIN_BITS'({mag5_ff[j], WIN_BITS'(0)} >> len_ff);
         end
         flg6_ff.neg  <= neg5_ff;
         flg6_ff.zero <= (len_ff == '0);
      end
   end

   // stage 7: squares
   logic [SQ_BITS-1:0]  sq_ff [3];
   logic [WIN_BITS-1:0] m7_ff [3];
   face_flags_type      flg7_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            sq_ff[j] <= SQ_BITS'(m6_ff[j]) * SQ_BITS'(m6_ff[j]);
         end
         m7_ff   <= m6_ff;
         flg7_ff <= flg6_ff;
      end
   end

   // stage 8: squared length
   logic [LEN2_BITS-1:0] len2_ff;
   logic [WIN_BITS-1:0]  m8_ff [3];
   face_flags_type       flg8_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         len2_ff <= LEN2_BITS'(sq_ff[0]) + LEN2_BITS'(sq_ff[1]) + LEN2_BITS'(sq_ff[2]);
         m8_ff   <= m7_ff;
         flg8_ff <= flg7_ff;
      end
   end

   // square root
   logic [ROOT_BITS-1:0] root;

   qfn_isqrt u_isqrt (
      .clock (clock),
      .adv   (adv),
      .len2  (len2_ff),
      .root  (root)
   );

   // delay lines beside the root and divider
   logic [WIN_BITS-1:0] m_dly_ff   [ROOT_BITS][3];
   face_flags_type      flg_dly_ff [ROOT_BITS + QW];

   always_ff @(posedge clock) begin
      if (adv) begin
         m_dly_ff[0]   <= m8_ff;
         flg_dly_ff[0] <= flg8_ff;
         for (int i = 1; i < ROOT_BITS; i++) begin
            m_dly_ff[i] <= m_dly_ff[i-1];
         end
         for (int i = 1; i < ROOT_BITS + QW; i++) begin
            flg_dly_ff[i] <= flg_dly_ff[i-1];
         end
      end
   end

   // divider lanes, rounded quotient m * one / r
   logic [ROOT_BITS-1:0] den;
   logic [NUMW-1:0]      num [3];
   logic [QW-1:0]        quo [3];

   assign den = (root == '0) ? ROOT_BITS'(1) : root;

   genvar g;
   generate
      for (g = 0; g < 3; g++) begin : g_lane
         assign num[g] = (NUMW'(m_dly_ff[ROOT_BITS-1][g]) << NORMAL_FRAC_BITS)
                       + NUMW'(den >> 1);

         qfn_div #(
            .NUM_BITS (NUMW),
            .DEN_BITS (ROOT_BITS),
            .Q_BITS   (QW)
         ) u_div (
            .clock (clock),
            .adv   (adv),
            .num   (num[g]),
            .den   (den),
            .quo   (quo[g])
         );
      end
   endgenerate

   // output stage: clamp, sign, zero case
   face_flags_type        flg_out;
   logic [EW-1:0]         one_e;
   logic [EW-1:0]         mag_e [3];
   logic [EW-1:0]         val_e [3];
   logic [NORMAL_BITS-1:0] nrm_ff [3];
   logic                  zero_ff;

   assign flg_out = flg_dly_ff[ROOT_BITS + QW - 1];

   always_comb begin
      one_e = EW'(1) << NORMAL_FRAC_BITS;
      for (int j = 0; j < 3; j++) begin
         mag_e[j] = (EW'(quo[j]) > one_e) ? one_e : EW'(quo[j]);
         val_e[j] = flg_out.neg[j] ? (~mag_e[j] + EW'(1)) : mag_e[j];
         if (flg_out.zero) begin
            val_e[j] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            nrm_ff[j] <= val_e[j][NORMAL_BITS-1:0];
         end
         zero_ff <= flg_out.zero;
      end
   end

   assign rsp_normal_x    = nrm_ff[0];
   assign rsp_normal_y    = nrm_ff[1];
   assign rsp_normal_z    = nrm_ff[2];
   assign rsp_zero_length = zero_ff;

endmodule
`default_nettype wire

[sim/tb_quad_face_unit_normal.sv]
// ----------------------------------------------------------------------------
// tb_quad_face_unit_normal
// Self-checking bench for the quad face unit normal pipeline. Faces are
// offered with random gaps and the result side stalls at random. Each
// accepted face is run through a local normal predictor, and each result is
// checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_quad_face_unit_normal;
   timeunit 1ns;
   timeprecision 1ps;
   import qfn_pkg::*;

   localparam int CB         = COORD_BITS_DEF;
   localparam int FRAC       = NORMAL_FRAC_BITS_DEF;
   localparam int IDLE_LIMIT = 3000;
   localparam int QUIET_LEFT = 150;

   typedef logic signed [CB-1:0] coord_type;
   typedef struct {
      coord_type p [12];
   } face_type;
   typedef struct {
      logic signed [NORMAL_BITS-1:0] x, y, z;
      logic                          zl;
   } normal_type;

   // kinds of generated face
   typedef enum int {
      FACE_WIDE, FACE_SMALL, FACE_DUP12, FACE_DUP23, FACE_DUP_BOTH, FACE_FLAT_PT
   } face_kind_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   coord_type drv_p [12] = '{default: '0};
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   logic signed [NORMAL_BITS-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic      rsp_zero_length;

   face_type   faces_pending [$];
   normal_type normals_due [$];
   int         n_err = 0;
   int         n_got = 0;
   int         idle_cycles = 0;
   int         send_gap = 0;
   int         recv_stall = 0;
   bit         held_off = 0;
   bit         quiet = 0;

   always #10 clock = ~clock;

   quad_face_unit_normal u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_c1_x(drv_p[0]), .req_c1_y(drv_p[1]), .req_c1_z(drv_p[2]),
      .req_c2_x(drv_p[3]), .req_c2_y(drv_p[4]), .req_c2_z(drv_p[5]),
      .req_c3_x(drv_p[6]), .req_c3_y(drv_p[7]), .req_c3_z(drv_p[8]),
      .req_c4_x(drv_p[9]), .req_c4_y(drv_p[10]), .req_c4_z(drv_p[11]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z), .rsp_zero_length(rsp_zero_length)
   );

   // integer square root, floor
   function automatic bit [63:0] isqrt(bit [63:0] x);
      bit [63:0] res;
      bit [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // expected unit normal of one face
   function automatic normal_type face_normal(face_type f);
      longint signed c [4][3];
      longint signed u [3];
      longint signed v [3];
      longint signed cr [3];
      bit [63:0]     mag [3];
      bit [63:0]     m [3];
      bit [63:0]     len2, r, n, t;
      bit            neg [3];
      int            a, b, d, maxlen, l, s;
      logic [NORMAL_BITS-1:0] comp [3];
      normal_type    e;
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 3; j++) c[i][j] = f.p[i*3+j];
      a = 0; b = 1; d = 2;
      if (c[0][0] == c[1][0] && c[0][1] == c[1][1] && c[0][2] == c[1][2]) begin
         a = 1; b = 2; d = 3;
      end
      // corner two equal to corner three takes precedence
      if (c[1][0] == c[2][0] && c[1][1] == c[2][1] && c[1][2] == c[2][2]) begin
         a = 0; b = 2; d = 3;
      end
      for (int j = 0; j < 3; j++) begin
         u[j] = c[b][j] - c[a][j];
         v[j] = c[d][j] - c[a][j];
      end
      cr[0] = u[1] * v[2] - u[2] * v[1];
      cr[1] = u[2] * v[0] - u[0] * v[2];
      cr[2] = u[0] * v[1] - u[1] * v[0];
      maxlen = 0;
      for (int j = 0; j < 3; j++) begin
         neg[j] = cr[j] < 0;
         mag[j] = neg[j] ? -cr[j] : cr[j];
         l = 0;
         t = mag[j];
         while (t != 0) begin
            l++;
            t = t >> 1;
         end
         if (l > maxlen) maxlen = l;
      end
      if (maxlen == 0) begin
         e.x = 0; e.y = 0; e.z = 0; e.zl = 1'b1;
         return e;
      end
      // bring the largest magnitude into the 30-bit window
      s = maxlen - WIN_BITS;
      len2 = 0;
      for (int j = 0; j < 3; j++) begin
         m[j] = (s > 0) ? (mag[j] >> s) : (mag[j] << (-s));
         len2 = len2 + m[j] * m[j];
      end
      r = isqrt(len2);
      if (r == 0) r = 1;
      for (int j = 0; j < 3; j++) begin
         n = ((m[j] << FRAC) + (r >> 1)) / r;
         if (n > (64'd1 << FRAC)) n = 64'd1 << FRAC;
         comp[j] = neg[j] ? NORMAL_BITS'(-n) : NORMAL_BITS'(n);
      end
      e.x = comp[0]; e.y = comp[1]; e.z = comp[2]; e.zl = 1'b0;
      return e;
   endfunction

   function automatic coord_type wide_coord();
      return coord_type'($urandom);
   endfunction

   function automatic coord_type small_coord();
      return coord_type'(int'($urandom_range(0, 8)) - 4);
   endfunction

   // random face of a given kind
   function automatic face_type random_face(face_kind_type kind);
      face_type f;
      bit       tiny;
      tiny = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < 12; i++)
         f.p[i] = (kind == FACE_SMALL || tiny) ? small_coord() : wide_coord();
      if (kind == FACE_DUP12 || kind == FACE_DUP_BOTH || kind == FACE_FLAT_PT)
         for (int j = 0; j < 3; j++) f.p[3+j] = f.p[j];
      if (kind == FACE_DUP23 || kind == FACE_DUP_BOTH || kind == FACE_FLAT_PT)
         for (int j = 0; j < 3; j++) f.p[6+j] = f.p[3+j];
      if (kind == FACE_FLAT_PT)
         for (int j = 0; j < 3; j++) f.p[9+j] = f.p[j];
      return f;
   endfunction

   function automatic face_type corners(coord_type a [3], coord_type b [3],
                                        coord_type c [3], coord_type d [3]);
      face_type f;
      for (int j = 0; j < 3; j++) begin
         f.p[j] = a[j]; f.p[3+j] = b[j]; f.p[6+j] = c[j]; f.p[9+j] = d[j];
      end
      return f;
   endfunction

   // driver: offers pending faces, random gaps between items
   always @(posedge clock) begin
      face_type cur;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            for (int i = 0; i < 12; i++) cur.p[i] = drv_p[i];
            normals_due.push_back(face_normal(cur));
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (faces_pending.size() > 0) begin
               cur = faces_pending.pop_front();
               for (int i = 0; i < 12; i++) drv_p[i] <= cur.p[i];
               req_valid <= 1'b1;
               if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 8);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks results, random and long stalls on the result side
   always @(posedge clock) begin
      normal_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_got <= n_got + 1;
            if (normals_due.size() == 0) begin
               $error("result with no face outstanding");
               n_err++;
            end else begin
               e = normals_due.pop_front();
               if (rsp_normal_x !== e.x) begin
                  $error("normal_x exp %0d got %0d", e.x, rsp_normal_x); n_err++;
               end
               if (rsp_normal_y !== e.y) begin
                  $error("normal_y exp %0d got %0d", e.y, rsp_normal_y); n_err++;
               end
               if (rsp_normal_z !== e.z) begin
                  $error("normal_z exp %0d got %0d", e.z, rsp_normal_z); n_err++;
               end
               if (rsp_zero_length !== e.zl) begin
                  $error("zero_length exp %0d got %0d", e.zl, rsp_zero_length); n_err++;
               end
            end
         end
         if (!held_off && n_got == 300) begin
            held_off <= 1'b1;
            recv_stall <= 400;
            rsp_ready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            recv_stall <= $urandom_range(0, 7);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus and end of run
   initial begin
      coord_type zero3 [3], hi3 [3], lo3 [3], ex [3], ey [3], ez [3], mx [3];
      zero3 = '{0, 0, 0};
      hi3 = '{24'sh7fffff, 24'sh7fffff, 24'sh7fffff};
      lo3 = '{-24'sh800000, -24'sh800000, -24'sh800000};
      ex = '{24'sh7fffff, 0, 0};
      ey = '{0, 24'sh7fffff, 0};
      ez = '{0, 0, 24'sh7fffff};
      mx = '{-24'sh800000, 24'sh7fffff, -24'sh800000};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed faces
      faces_pending.push_back(corners(zero3, zero3, zero3, zero3));
      faces_pending.push_back(corners(hi3, hi3, hi3, hi3));
      faces_pending.push_back(corners(zero3, ex, ey, ez));
      faces_pending.push_back(corners(zero3, ey, ex, ez));
      faces_pending.push_back(corners(lo3, ex, ey, hi3));
      faces_pending.push_back(corners(hi3, lo3, mx, ez));
      faces_pending.push_back(corners(lo3, hi3, ex, mx));
      faces_pending.push_back(corners(mx, lo3, hi3, zero3));
      faces_pending.push_back(corners(zero3, zero3, ex, ey));     // corner one on two
      faces_pending.push_back(corners(ex, ey, ey, ez));           // corner two on three
      faces_pending.push_back(corners(ez, ez, ez, ey));           // both duplicates
      faces_pending.push_back(corners(zero3, ex, hi3, lo3));      // third corner on the far diagonal
      faces_pending.push_back(corners(zero3, '{1, 0, 0}, '{0, 1, 0}, ez));
      faces_pending.push_back(corners(zero3, '{1, 0, 0}, '{2, 0, 0}, zero3));
      faces_pending.push_back(corners(lo3, '{-24'sh800000, -24'sh800000, -24'sh7fffff},
                                      '{-24'sh7fffff, -24'sh800000, -24'sh800000}, zero3));
      for (int k = 0; k < 6; k++)
         faces_pending.push_back(random_face(face_kind_type'(k)));

      // sender pauses until the directed results are all back
      wait (faces_pending.size() == 0 && !req_valid && normals_due.size() == 0);
      @(posedge clock);

      for (int k = 0; k < 1430; k++) begin
         int pick;
         pick = $urandom_range(0, 9);
         faces_pending.push_back(random_face(pick < 5 ? FACE_WIDE :
                                             pick < 7 ? FACE_SMALL :
                                             face_kind_type'(pick - 5)));
      end
      wait (faces_pending.size() < QUIET_LEFT);
      quiet = 1'b1;
      wait (faces_pending.size() == 0 && !req_valid && normals_due.size() == 0);
      repeat (80) @(posedge clock);
      if (n_err == 0 && normals_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[sim.f]
src/qfn_pkg.sv
src/qfn_isqrt.sv
src/qfn_div.sv
src/quad_face_unit_normal.sv
sim/tb_quad_face_unit_normal.sv
